/* rtl/bse_pkg.sv */
package bse_pkg;

  // Fixed field widths of the request and result ports.
  localparam int KIND_W   = 3;
  localparam int ITEM_W   = 32;
  localparam int RESULT_W = 32;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 7;
  localparam int COUNT_W  = 7;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Operation codes.
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SORT   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Status flags that travel with each result.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic                is_full;
    logic                is_empty;
  } bse_flags_t;

endpackage

/* rtl/bounded_stack_engine_unit.sv */
// Push goes from idle straight to the finish state; pop and peek add one memory read.
// Search: one entry per cycle from the top, stopping on a hit.
// Sort: bubble passes that shrink by one entry each, paced by the
// single read port and single write port of the entry memory.
// One request is in flight at a time; the output register lets the next request in.
// Reset (rst_ni low, asynchronous) empties the stack and sets capacity to 64.
module bounded_stack_engine_unit #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bse_pkg::CAP_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bse_pkg::KIND_W-1:0]        kind_i,
  input  logic signed [bse_pkg::ITEM_W-1:0] item_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bse_pkg::RESULT_W-1:0] result_value_o,
  output logic [bse_pkg::STATUS_W-1:0]      status_o,
  output logic                              found_o,
  output logic                              is_full_o,
  output logic                              is_empty_o,
  output logic [bse_pkg::COUNT_W-1:0]       count_o
);
  import bse_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CAP_W-1:0]      cap_q;
  logic [RESULT_W-1:0]   res_val;
  bse_flags_t            flags;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // Capacity register, always ready for a write.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  bse_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cap_i          (cap_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .item_value_i   (item_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (res_val),
    .flags_o        (flags),
    .count_o        (count_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  bse_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Split the flag group onto the result ports.
  assign result_value_o = $signed(res_val);
  assign status_o       = flags.status;
  assign found_o        = flags.found;
  assign is_full_o      = flags.is_full;
  assign is_empty_o     = flags.is_empty;

endmodule

/* rtl/bse_mem.sv */
module bse_mem #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [DATA_WIDTH-1:0]      wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [DATA_WIDTH-1:0]      rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bse_ctrl.sv */
module bse_ctrl #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bse_pkg::CAP_W-1:0]     cap_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bse_pkg::KIND_W-1:0]    kind_i,
  input  logic signed [bse_pkg::ITEM_W-1:0] item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bse_pkg::RESULT_W-1:0]  result_value_o,
  output bse_pkg::bse_flags_t           flags_o,
  output logic [bse_pkg::COUNT_W-1:0]   count_o,
  output logic                          mem_we_o,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr_o,
  output logic [DATA_WIDTH-1:0]         mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]         mem_rdata_i
);
  import bse_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [63:0] SIGN64 = 64'(1) << (DATA_WIDTH - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SRCH  = 3'd2;
  localparam logic [2:0] S_SLOAD = 3'd3;
  localparam logic [2:0] S_SRUN  = 3'd4;
  localparam logic [2:0] S_SLAST = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [AW-1:0]         last_q, last_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [DATA_WIDTH-1:0] cur_q, cur_d;
  logic [RESULT_W-1:0]   res_val_q, res_val_d;
  logic [STATUS_W-1:0]   res_st_q, res_st_d;
  logic                  res_found_q, res_found_d;
  logic                  out_valid_q, out_valid_d;
  logic [RESULT_W-1:0]   out_val_q;
  bse_flags_t            out_flags_q;
  logic [COUNT_W-1:0]    out_cnt_q;
  logic                  in_fire;
  logic                  out_load;
  logic [EW-1:0]         cap_ext;
  logic [EW-1:0]         eff_cap;
  logic                  full_now;
  logic [63:0]           rdata_ext;

  // Effective capacity is the register clamped to 1..DEPTH.
  assign cap_ext = EW'(cap_i);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(DEPTH)) begin
      eff_cap = EW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full_now   = (EW'(cnt_q) >= eff_cap);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign rdata_ext  = 64'(mem_rdata_i);

  // Operation sequencer with read-modify-write access to the entry memory.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    val_d       = val_q;
    cur_d       = cur_q;
    res_val_d   = res_val_q;
    res_st_d    = res_st_q;
    res_found_d = res_found_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = cur_q;
    mem_raddr_o = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d       = DATA_WIDTH'($unsigned(item_value_i));
          res_val_d   = '0;
          res_st_d    = ST_OK;
          res_found_d = 1'b0;
          state_d     = S_FIN;
          case (kind_i)
            KIND_PUSH: begin
              if (full_now) begin
                res_st_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(cnt_q);
                mem_wdata_o = DATA_WIDTH'($unsigned(item_value_i));
                cnt_d       = cnt_q + 1'b1;
              end
            end
            KIND_POP, KIND_PEEK: begin
              if (cnt_q == '0) begin
                res_st_d  = ST_EMPTY;
                res_val_d = SIGN64[RESULT_W-1:0];
              end else begin
                mem_raddr_o = AW'(cnt_q - 1'b1);
                state_d     = S_READ;
                if (kind_i == KIND_POP) begin
                  cnt_d = cnt_q - 1'b1;
                end
              end
            end
            KIND_SEARCH: begin
              if (cnt_q != '0) begin
                mem_raddr_o = AW'(cnt_q - 1'b1);
                ptr_d       = AW'(cnt_q - 1'b1);
                state_d     = S_SRCH;
              end
            end
            KIND_SORT: begin
              if (cnt_q > CW'(1)) begin
                mem_raddr_o = '0;
                last_d      = AW'(cnt_q - 1'b1);
                state_d     = S_SLOAD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        res_val_d = rdata_ext[RESULT_W-1:0];
        state_d   = S_FIN;
      end

      // Scan from the top down, one entry per cycle.
      S_SRCH: begin
        if (mem_rdata_i == val_q) begin
          res_found_d = 1'b1;
          state_d     = S_FIN;
        end else if (ptr_q == '0) begin
          state_d = S_FIN;
        end else begin
          ptr_d       = ptr_q - 1'b1;
          mem_raddr_o = ptr_q - 1'b1;
        end
      end

      // Start of a bubble pass: the bottom entry becomes the carried word.
      S_SLOAD: begin
        cur_d       = mem_rdata_i;
        ptr_d       = '0;
        mem_raddr_o = AW'(1);
        state_d     = S_SRUN;
      end

      // Carry the larger word upward, write the smaller one back.
      S_SRUN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        if ($signed(cur_q) > $signed(mem_rdata_i)) begin
          mem_wdata_o = mem_rdata_i;
        end else begin
          mem_wdata_o = cur_q;
          cur_d       = mem_rdata_i;
        end
        mem_raddr_o = ptr_q + AW'(2);
        if (ptr_q + 1'b1 == last_q) begin
          state_d = S_SLAST;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      // The carried word lands at the top of the pass.
      S_SLAST: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = last_q;
        mem_wdata_o = cur_q;
        mem_raddr_o = '0;
        if (last_q == AW'(1)) begin
          state_d = S_FIN;
        end else begin
          last_d  = last_q - 1'b1;
          state_d = S_SLOAD;
        end
      end

      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    last_q      <= last_d;
    val_q       <= val_d;
    cur_q       <= cur_d;
    res_val_q   <= res_val_d;
    res_st_q    <= res_st_d;
    res_found_q <= res_found_d;
  end

  // Output register, loaded when the result slot is free.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q            <= res_val_q;
      out_flags_q.status   <= res_st_q;
      out_flags_q.found    <= res_found_q;
      out_flags_q.is_full  <= full_now;
      out_flags_q.is_empty <= (cnt_q == '0);
      out_cnt_q            <= COUNT_W'(cnt_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign flags_o        = out_flags_q;
  assign count_o        = out_cnt_q;

  // The fill count never passes the memory depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("fill count above depth");

  // During a sort pass the write and the read never hit the same entry.
  a_sort_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRUN) |-> (mem_waddr_o != mem_raddr_o))
    else $error("sort read and write collide");

  // An accepted push with room grows the stack by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && kind_i == KIND_PUSH && !full_now) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not grow the stack");

  // A result appears only from the finishing state.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result without finished request");

  // A sort pass always covers at least two entries.
  a_pass_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRUN || state_q == S_SLAST) |-> last_q != '0)
    else $error("empty sort pass");

endmodule

/* bench/bounded_stack_engine_unit_checker.sv */
`timescale 1ns / 1ps

module bounded_stack_engine_unit_checker #(
  parameter int DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [bse_pkg::CAP_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [bse_pkg::KIND_W-1:0]          kind_i,
  input  logic signed [bse_pkg::ITEM_W-1:0]   item_value_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [bse_pkg::RESULT_W-1:0] result_value_i,
  input  logic [bse_pkg::STATUS_W-1:0]        status_i,
  input  logic                                found_i,
  input  logic                                is_full_i,
  input  logic                                is_empty_i,
  input  logic [bse_pkg::COUNT_W-1:0]         count_i,
  output int                                  fail_count_o,
  output int                                  outstanding_o,
  output int                                  results_checked_o,
  output int                                  full_rejects_o,
  output int                                  empty_reads_o,
  output int                                  search_hits_o
);

  import bse_pkg::*;

  typedef struct packed {
    logic signed [RESULT_W-1:0] result_value;
    logic [STATUS_W-1:0]        status;
    logic                       found;
    logic                       is_full;
    logic                       is_empty;
    logic [COUNT_W-1:0]         count;
  } stack_result_t;

  // Shadow copy of the stack contents and its settings.
  logic signed [ITEM_W-1:0] words [DEPTH];
  int                       depth_used;
  logic [CAP_W-1:0]         cap_setting;
  stack_result_t            expected_q [$];

  // A capacity of zero behaves as one, anything above the depth as the depth.
  function automatic int cap_limit();
    if (cap_setting == '0) return 1;
    if (int'(cap_setting) > DEPTH) return DEPTH;
    return int'(cap_setting);
  endfunction

  // Apply one request to the shadow stack and return the result it should give.
  function automatic stack_result_t apply_request(input logic [KIND_W-1:0] op,
                                                  input logic signed [ITEM_W-1:0] word);
    stack_result_t r;
    int lim;
    int i;
    int j;
    logic signed [ITEM_W-1:0] tmp;
    lim = cap_limit();
    r = '0;
    case (op)
      KIND_PUSH: begin
        if (depth_used >= lim) begin
          r.status = ST_FULL;
        end else begin
          words[depth_used] = word;
          depth_used++;
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (depth_used == 0) begin
          r.status = ST_EMPTY;
          r.result_value = {1'b1, {(RESULT_W-1){1'b0}}};
        end else begin
          r.result_value = words[depth_used-1];
          if (op == KIND_POP) depth_used--;
        end
      end
      KIND_SEARCH: begin
        // Scan from the top down; the first hit ends the scan.
        for (i = depth_used; i > 0 && !r.found; i--) begin
          if (words[i-1] == word) r.found = 1'b1;
        end
      end
      KIND_SORT: begin
        // Bubble sort, ascending from the bottom, signed comparison.
        for (i = 0; i < depth_used; i++) begin
          for (j = 0; j + 1 + i < depth_used; j++) begin
            if (words[j] > words[j+1]) begin
              tmp = words[j];
              words[j] = words[j+1];
              words[j+1] = tmp;
            end
          end
        end
      end
      default: begin
      end
    endcase
    r.is_full  = (depth_used >= lim);
    r.is_empty = (depth_used == 0);
    r.count    = COUNT_W'(depth_used);
    return r;
  endfunction

  function automatic void compare_field(input string field,
                                        input logic signed [63:0] want,
                                        input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count_o++;
    end
  endfunction

  // Track configuration writes, predict accepted requests, and check results.
  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t want;
    stack_result_t pred;
    if (!rst_ni) begin
      depth_used = 0;
      cap_setting = CAP_RESET;
      expected_q.delete();
      outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) cap_setting = cfg_data_i;

      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no request waiting for it");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          results_checked_o++;
          compare_field("result_value", 64'(want.result_value), 64'(result_value_i));
          compare_field("status", 64'(want.status), 64'(status_i));
          compare_field("found", 64'(want.found), 64'(found_i));
          compare_field("is_full", 64'(want.is_full), 64'(is_full_i));
          compare_field("is_empty", 64'(want.is_empty), 64'(is_empty_i));
          compare_field("count", 64'(want.count), 64'(count_i));
        end
      end

      if (in_valid_i && in_ready_i) begin
        pred = apply_request(kind_i, item_value_i);
        if (pred.status == ST_FULL) full_rejects_o++;
        if (pred.status == ST_EMPTY) empty_reads_o++;
        if (pred.found) search_hits_o++;
        expected_q.push_back(pred);
      end

      outstanding_o = expected_q.size();
    end
  end

endmodule

/* bench/bounded_stack_engine_unit_tb.sv */
`timescale 1ns / 1ps

module bounded_stack_engine_unit_tb;

  import bse_pkg::*;

  localparam int DEPTH          = 64;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 112;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_PHASE     = 4;

  localparam logic [KIND_W-1:0] KIND_LAST    = 3'd7;
  localparam logic [ITEM_W-1:0] WORD_MIN     = 32'h8000_0000;
  localparam logic [ITEM_W-1:0] WORD_MAX     = 32'h7fff_ffff;
  localparam logic [CAP_W-1:0]  CAP_ALL_ONES = 7'h7f;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CAP_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [KIND_W-1:0]          kind = '0;
  logic signed [ITEM_W-1:0]   item_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [RESULT_W-1:0] result_value;
  logic [STATUS_W-1:0]        status;
  logic                       found;
  logic                       is_full;
  logic                       is_empty;
  logic [COUNT_W-1:0]         count;

  int fail_count;
  int outstanding;
  int results_checked;
  int full_rejects;
  int empty_reads;
  int search_hits;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int requests_sent = 0;
  int config_writes = 0;
  int quiet_cycles = 0;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_stack_engine_unit uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .item_value_i   (item_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_value_o (result_value),
    .status_o       (status),
    .found_o        (found),
    .is_full_o      (is_full),
    .is_empty_o     (is_empty),
    .count_o        (count)
  );

  bounded_stack_engine_unit_checker #(
    .DEPTH (DEPTH)
  ) stack_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .kind_i            (kind),
    .item_value_i      (item_value),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .result_value_i    (result_value),
    .status_i          (status),
    .found_i           (found),
    .is_full_i         (is_full),
    .is_empty_i        (is_empty),
    .count_i           (count),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding),
    .results_checked_o (results_checked),
    .full_rejects_o    (full_rejects),
    .empty_reads_o     (empty_reads),
    .search_hits_o     (search_hits)
  );

  // Result side: random stalls, or a long hold-off when the stimulus asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // End the run if nothing moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("bounded_stack_engine_unit_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request after an optional random gap and wait for it to be taken.
  task automatic send_request(input logic [KIND_W-1:0] op, input logic [ITEM_W-1:0] word);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= op;
    item_value <= word;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Stop offering and wait until every request has produced its result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Called only while the block is idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    config_writes++;
  endtask

  // Operation mix: pushes at the given percentage, the rest spread over the others.
  function automatic logic [KIND_W-1:0] pick_kind(input int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < push_pct) return KIND_PUSH;
    r = $urandom_range(99);
    if (r < 45) return KIND_POP;
    if (r < 62) return KIND_PEEK;
    if (r < 84) return KIND_SEARCH;
    if (r < 94) return KIND_SORT;
    return KIND_LAST - KIND_W'($urandom_range(2));
  endfunction

  // Small values give repeats for search and sort; the rest spans the full word.
  function automatic logic [ITEM_W-1:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r < 4) return ITEM_W'($urandom_range(15)) - ITEM_W'(8);
    if (r == 4) begin
      case ($urandom_range(3))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  initial begin
    logic [CAP_W-1:0] cap_plan [RANDOM_PHASES];
    int push_pct;
    int p;
    int n;

    cap_plan[0]  = CAP_RESET;
    cap_plan[1]  = CAP_ALL_ONES;
    cap_plan[2]  = 7'd1;
    cap_plan[3]  = '0;
    cap_plan[4]  = CAP_RESET;
    cap_plan[5]  = 7'd2;
    cap_plan[6]  = CAP_W'($urandom_range(63, 3));
    cap_plan[7]  = CAP_RESET;
    cap_plan[8]  = 7'd63;
    cap_plan[9]  = CAP_W'($urandom_range(127));
    cap_plan[10] = 7'd5;
    cap_plan[11] = CAP_RESET;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty stack: pop and peek report empty, search and sort do nothing.
    send_request(KIND_POP, '0);
    send_request(KIND_PEEK, '0);
    send_request(KIND_SEARCH, WORD_MIN);
    send_request(KIND_SORT, '0);
    send_request(KIND_SORT + 3'd1, WORD_MAX);
    send_request(KIND_LAST, '1);

    // Extreme words, then search hit and miss, sort, and reads of the new top.
    send_request(KIND_PUSH, WORD_MAX);
    send_request(KIND_PUSH, WORD_MIN);
    send_request(KIND_PUSH, '0);
    send_request(KIND_PUSH, '1);
    send_request(KIND_PUSH, 32'd5);
    send_request(KIND_PEEK, '0);
    send_request(KIND_SEARCH, WORD_MIN);
    send_request(KIND_SEARCH, 32'd12345);
    send_request(KIND_SORT, '0);
    send_request(KIND_PEEK, '0);
    send_request(KIND_POP, '0);
    wait_drained();

    // Capacity lowered below the count: nothing is dropped, pushes are refused.
    write_capacity(7'd2);
    send_request(KIND_PUSH, 32'd7);
    send_request(KIND_PEEK, '0);
    wait_drained();

    // Capacity zero behaves as one.
    write_capacity('0);
    send_request(KIND_PUSH, 32'd9);
    send_request(KIND_POP, '0);
    send_request(KIND_POP, '0);
    send_request(KIND_POP, '0);
    send_request(KIND_PUSH, 32'd11);
    send_request(KIND_POP, '0);
    send_request(KIND_PUSH, 32'd13);
    wait_drained();

    // Capacity above the depth clamps to the depth.
    write_capacity(CAP_ALL_ONES);
    send_request(KIND_PUSH, 32'd15);
    wait_drained();

    // Random phases, each with its own capacity, operation mix and idling pattern.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 50;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 50;
        end
        default: begin
          idle_pct = 16;
          stall_pct <= 16;
        end
      endcase
      push_pct = (p % 3 == 2) ? 25 : 70;
      write_capacity(cap_plan[p]);
      // Hold off results for a long stretch while requests keep coming.
      if (p == HOLD_PHASE) hold_asked <= hold_asked + 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_request(pick_kind(push_pct), pick_word());
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d requests across %0d capacity settings; %0d results checked.",
             requests_sent, config_writes, results_checked);
    $display("Refused pushes: %0d, reads of an empty stack: %0d, search hits: %0d.",
             full_rejects, empty_reads, search_hits);
    if (fail_count == 0 && outstanding == 0) begin
      $display("bounded_stack_engine_unit_tb: PASS");
    end else begin
      $display("bounded_stack_engine_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
